>>> design/mbf_pkg.sv
// Shared constants and types for the MBF/IEEE double converter.
package mbf_pkg;

    localparam logic [1:0] OP_DEC4 = 2'd0;
    localparam logic [1:0] OP_DEC8 = 2'd1;
    localparam logic [1:0] OP_ENC4 = 2'd2;
    localparam logic [1:0] OP_ENC8 = 2'd3;

    localparam logic [10:0] BIAS_SHIFT = 11'd894;
    localparam logic [10:0] EXP_MAX    = 11'h7FF;
    localparam logic [7:0]  MEXP_MAX   = 8'hFF;

    // stage 1 -> stage 2: field decode
    typedef struct packed {
        logic [1:0]  op;
        logic        sg;
        logic [7:0]  mexp;      // MBF exponent byte (decode)
        logic [10:0] dexp;      // IEEE exponent (encode)
        logic [54:0] frac;      // MBF fraction (decode) or IEEE fraction (encode)
        logic        zero;      // decode exponent byte zero / encode signed zero
        logic        rnd_up;    // MBF8 round increment
    } mbf_s1_t;

    // stage 2 -> stage 3: rounded / classified
    typedef struct packed {
        logic [1:0]  op;
        logic        sg;
        logic [10:0] exp;
        logic [52:0] sig;       // for decode: 53-bit significand incl. possible carry
        logic [51:0] frac;      // encode fraction
        logic        zero;
        logic        uf;
        logic        cl;
    } mbf_s2_t;

endpackage

>>> design/mbf_ieee_double_converter.sv
// Top level: pipelined converter between MBF numbers and IEEE doubles.
//
// Input channel s_valid/s_ready carries s_op and s_value; result channel
// m_valid/m_ready carries m_result, m_underflowed and m_clamped.
// op 0/1 decode MBF4/MBF8 to a double (MBF8 rounds to nearest even),
// op 2/3 encode a double to MBF4/MBF8 (truncating, flags for flush/clamp).
// Three register stages: field split and round decision, rounding add and
// exponent classification, result packing. One item is accepted every
// cycle unless a stall on m_ready holds the output register.
// Each stage advances when it is empty or the stage after it advances, so
// a stall on m_ready backs up through the pipe without losing or repeating
// items; s_ready drops only when all three stages hold data and the output
// is stalled. aresetn (synchronous, active low) empties the pipe.
module mbf_ieee_double_converter
    import mbf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [63:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result,
    output logic        m_underflowed,
    output logic        m_clamped
);

    logic v1_reg, v2_reg, v3_reg;
    mbf_s1_t s1_reg, s1_next;
    mbf_s2_t s2_reg, s2_next;
    logic [63:0] res_reg, res_next;
    logic uf_reg, cl_reg;
    logic adv1, adv2, adv3;

    assign adv3 = !v3_reg || m_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_ready = adv1;

    // stage 1: field split
    always_comb begin
        s1_next = '0;
        s1_next.op = s_op;
        if (s_op == OP_DEC4) begin
            s1_next.mexp = s_value[31:24];
            s1_next.sg   = s_value[23];
            s1_next.frac = {s_value[22:0], 32'd0};
            s1_next.zero = (s_value[31:24] == 8'd0);
        end else if (s_op == OP_DEC8) begin
            s1_next.mexp = s_value[63:56];
            s1_next.sg   = s_value[55];
            s1_next.frac = s_value[54:0];
            s1_next.zero = (s_value[63:56] == 8'd0);
            s1_next.rnd_up = (s_value[2:0] > 3'd4)
                || (s_value[2:0] == 3'd4 && s_value[3]);
        end else begin
            s1_next.sg   = s_value[63];
            s1_next.dexp = s_value[62:52];
            s1_next.frac = {3'd0, s_value[51:0]};
            s1_next.zero = (s_value[62:0] == 63'd0);
        end
    end

    // stage 2: rounding add, exponent classification
    always_comb begin
        logic [10:0] d;
        // only used when dexp is above the bias
        d = s1_reg.dexp - BIAS_SHIFT;
        s2_next = '0;
        s2_next.op   = s1_reg.op;
        s2_next.sg   = s1_reg.sg;
        s2_next.zero = s1_reg.zero;
        if (!s1_reg.op[1]) begin
            s2_next.exp = {3'd0, s1_reg.mexp} + BIAS_SHIFT;
            s2_next.sig = {1'b1, s1_reg.frac[54:3]} + {52'd0, s1_reg.rnd_up};
        end else begin
            s2_next.frac = s1_reg.frac[51:0];
            if (s1_reg.zero) begin
                s2_next.exp = '0;
            end else if (s1_reg.dexp == EXP_MAX) begin
                s2_next.exp = {3'd0, MEXP_MAX};
                s2_next.cl  = 1'b1;
                s2_next.frac = '0;
                if (s1_reg.frac[51:0] != 52'd0) s2_next.sg = 1'b0;
            end else if (s1_reg.dexp <= BIAS_SHIFT) begin
                s2_next.uf = 1'b1;
            end else if (d > {3'd0, MEXP_MAX}) begin
                s2_next.exp = {3'd0, MEXP_MAX};
                s2_next.cl  = 1'b1;
            end else begin
                s2_next.exp = d;
            end
        end
    end

    // stage 3: pack
    always_comb begin
        res_next = '0;
        if (!s2_reg.op[1]) begin
            if (!s2_reg.zero) begin
                if (s2_reg.sig[52] == 1'b0)   // carry out: 2^53 wrapped
                    res_next = {s2_reg.sg, s2_reg.exp + 11'd1, 52'd0};
                else
                    res_next = {s2_reg.sg, s2_reg.exp, s2_reg.sig[51:0]};
            end
        end else if (!s2_reg.zero && !s2_reg.uf) begin
            if (s2_reg.op == OP_ENC8)
                res_next = {s2_reg.exp[7:0], s2_reg.sg, s2_reg.frac, 3'd0};
            else
                res_next = {32'd0, s2_reg.exp[7:0], s2_reg.sg, s2_reg.frac[51:29]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3) begin
            res_reg <= res_next;
            uf_reg  <= s2_reg.uf;
            cl_reg  <= s2_reg.cl;
        end
    end

    assign m_valid       = v3_reg;
    assign m_result      = res_reg;
    assign m_underflowed = uf_reg;
    assign m_clamped     = cl_reg;

endmodule

>>> design/mbf_checker.sv
// Port-level checker for the MBF/IEEE double converter, bound to the top level.
module mbf_checker
    import mbf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_result,
    input logic        m_underflowed,
    input logic        m_clamped
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result changed while stalled");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_underflowed && m_clamped))
        else $error("both flags set");

    a_uf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_underflowed |-> m_result == 64'd0)
        else $error("underflow with nonzero bytes");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid after reset");

endmodule

bind mbf_ieee_double_converter mbf_checker u_mbf_checker (.*);

>>> verif/mbf_ieee_double_converter_test.sv
// Testbench for the MBF/IEEE double converter: random and directed conversions checked in order.
module mbf_ieee_double_converter_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mbf_pkg::*;

    typedef struct {
        logic [63:0] result;
        logic        uf;
        logic        cl;
    } conv_out_t;

    class conv_scoreboard;
        conv_out_t pending[$];
        int        errors = 0;

        function conv_out_t convert(logic [1:0] op, logic [63:0] v);
            conv_out_t   o;
            logic [63:0] sig;
            logic [53:0] q;
            logic [2:0]  r;
            logic [10:0] e;
            logic [11:0] mx;
            logic [51:0] f;
            logic        sg;
            o.result = '0;
            o.uf = 1'b0;
            o.cl = 1'b0;
            case (op)
                OP_DEC4: begin
                    if (v[31:24] != 8'd0)
                        o.result = {v[23], 11'(v[31:24]) + BIAS_SHIFT, v[22:0], 29'd0};
                end
                OP_DEC8: begin
                    if (v[63:56] != 8'd0) begin
                        sig = {8'd0, 1'b1, v[54:0]};
                        q = {1'b0, sig[55:3]};
                        r = sig[2:0];
                        if (r > 3'd4 || (r == 3'd4 && q[0])) q = q + 54'd1;
                        e = 11'(v[63:56]) + BIAS_SHIFT;
                        if (q[53]) begin
                            q = q >> 1;
                            e = e + 11'd1;
                        end
                        o.result = {v[55], e, q[51:0]};
                    end
                end
                default: begin
                    sg = v[63];
                    e = v[62:52];
                    f = v[51:0];
                    if (v[62:0] != 63'd0) begin
                        if (e == EXP_MAX) begin
                            if (f != 52'd0) sg = 1'b0;   // NaN goes positive
                            f = '0;
                            mx = 12'd255;
                            o.cl = 1'b1;
                        end else if (e <= BIAS_SHIFT) begin
                            o.uf = 1'b1;
                            mx = 12'd0;
                        end else begin
                            mx = {1'b0, e - BIAS_SHIFT};
                            if (mx > 12'd255) begin
                                mx = 12'd255;
                                o.cl = 1'b1;
                            end
                        end
                        if (!o.uf) begin
                            if (op == OP_ENC8)
                                o.result = {mx[7:0], sg, f, 3'd0};
                            else
                                o.result = {32'd0, mx[7:0], sg, f[51:29]};
                        end
                    end
                end
            endcase
            return o;
        endfunction

        function void note_input(logic [1:0] op, logic [63:0] v);
            pending.push_back(convert(op, v));
        endfunction

        function void check_result(logic [63:0] res, logic uf, logic cl);
            conv_out_t x;
            if (pending.size() == 0) begin
                $error("unexpected result %h", res);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (res !== x.result) begin
                $error("result: expected %h actual %h", x.result, res);
                errors++;
            end
            if (uf !== x.uf) begin
                $error("underflowed: expected %b actual %b", x.uf, uf);
                errors++;
            end
            if (cl !== x.cl) begin
                $error("clamped: expected %b actual %b", x.cl, cl);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = '0;
    logic [63:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result;
    logic        m_underflowed;
    logic        m_clamped;

    conv_scoreboard board = new();
    bit   sending_done = 1'b0;
    bit   long_hold = 1'b0;
    int   cycles = 0;

    mbf_ieee_double_converter dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("FAIL mbf_ieee_double_converter");
            $finish;
        end
    end

    // valid stays high into the next word when there is no gap
    task automatic send_word(logic [1:0] op, logic [63:0] v, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        board.note_input(op, v);
    endtask

    // keep valid high between back-to-back words
    task automatic send_run(logic [1:0] op, logic [63:0] v, int gap);
        send_word(op, v, gap);
    endtask

    function automatic logic [63:0] rand_word(logic [1:0] op);
        logic [63:0] v;
        logic [10:0] e;
        v = {$urandom, $urandom};
        if (op >= OP_ENC4) begin
            case ($urandom_range(0, 5))
                0: e = 11'($urandom_range(0, 894));
                1: e = 11'($urandom_range(1149, 2047));
                2: e = 11'd2047;
                default: e = 11'($urandom_range(895, 1150));
            endcase
            v[62:52] = e;
            if ($urandom_range(0, 9) == 0) v[51:0] = '0;
        end else if ($urandom_range(0, 9) == 0) begin
            v[63:56] = 8'd0;
            v[31:24] = 8'd0;
        end else if ($urandom_range(0, 5) == 0) begin
            v[2:0] = 3'd4;    // rounding tie
        end
        return v;
    endfunction

    // receiver
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (60) @(posedge aclk);
                long_hold = 1'b0;
            end
            w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
            if (w != 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_result(m_result, m_underflowed, m_clamped);
        end
    end

    initial begin
        logic [1:0] op;
        int gap;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_word(OP_DEC4, 64'hFFFF_FFFF_0000_0000, 0);
        send_word(OP_DEC4, 64'h0000_0000_FFFF_FFFF, 0);
        send_word(OP_DEC4, 64'h0000_0000_00FF_FFFF, 0);
        send_word(OP_DEC4, 64'h0000_0000_0180_0000, 0);
        send_word(OP_DEC8, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_word(OP_DEC8, 64'h00FF_FFFF_FFFF_FFFF, 0);
        send_word(OP_DEC8, 64'h0100_0000_0000_0004, 0);
        send_word(OP_DEC8, 64'h0100_0000_0000_000C, 0);
        send_word(OP_DEC8, 64'h817F_FFFF_FFFF_FFFC, 0);
        send_word(OP_ENC4, 64'h0000_0000_0000_0000, 0);
        send_word(OP_ENC8, 64'h8000_0000_0000_0000, 0);
        send_word(OP_ENC4, 64'h0000_0000_0000_0001, 0);
        send_word(OP_ENC8, 64'h37E0_0000_0000_0000, 0);
        send_word(OP_ENC8, 64'h37F0_0000_0000_0000, 0);
        send_word(OP_ENC4, 64'hBFF0_0000_0000_0000, 0);
        send_word(OP_ENC8, 64'h47E0_FFFF_FFFF_FFFF, 0);
        send_word(OP_ENC4, 64'hC7F0_0000_0000_0000, 0);
        send_word(OP_ENC8, 64'hFFF0_0000_0000_0000, 0);
        send_word(OP_ENC4, 64'hFFF0_0000_0000_0001, 0);
        send_word(OP_ENC8, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_word(OP_ENC8, 64'h7FEF_FFFF_FFFF_FFFF, 0);
        for (int i = 0; i < 600; i++) begin
            if (i == 200) begin
                long_hold = 1'b1;
            end
            if (i == 400) begin
                // drain before continuing
                s_valid <= 1'b0;
                wait (board.pending.size() == 0);
                @(posedge aclk);
            end
            op = 2'($urandom_range(0, 3));
            gap = ($urandom_range(0, 2) == 0 || (i >= 200 && i < 260)) ? 0
                  : $urandom_range(0, 13);
            send_run(op, rand_word(op), gap);
        end
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (board.errors == 0)
            $display("PASS mbf_ieee_double_converter");
        else
            $display("FAIL mbf_ieee_double_converter");
        $finish;
    end

endmodule
